// ===== design/assert_macros.svh =====
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

// ===== design/pwa_pkg.sv =====
// Shared widths, codes and interface types of the pulse waveform accumulator.
package pwa_pkg;
  localparam int OP_W       = 2;
  localparam int CH_W       = 2;
  localparam int T_W        = 20;
  localparam int AMP_W      = 16;
  localparam int LEN_W      = 16;
  localparam int IDX_W      = 11;
  localparam int VAL_W      = 32;
  localparam int BW_W       = 8;
  localparam int NUM_W      = 26;
  localparam int DEN_W      = 32;
  localparam int IN_TDATA_W = 72;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [OP_W-1:0] OP_DEPOSIT = 2'd0;
  localparam logic [OP_W-1:0] OP_READ    = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_SHAPE     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BIN_WIDTH = 1'd1;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [NUM_W-1:0] quot;
    logic [DEN_W-1:0] rem;
  } div_rsp_t;
endpackage

// ===== design/pwa_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
module pwa_div (
  input  logic              clk,
  input  logic              rst_n,
  input  pwa_pkg::div_req_t req,
  output pwa_pkg::div_rsp_t rsp
);
  import pwa_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [NUM_W-1:0] quo_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;

  assign trial = {rem_r, quo_r[NUM_W-1]};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
        quo_r  <= req.num;
        den_r  <= req.den;
        rem_r  <= '0;
      end else if (busy_r) begin
        if (diff[DEN_W]) begin
          rem_r <= trial[DEN_W-1:0];
          quo_r <= {quo_r[NUM_W-2:0], 1'b0};
        end else begin
          rem_r <= diff[DEN_W-1:0];
          quo_r <= {quo_r[NUM_W-2:0], 1'b1};
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quot = quo_r;
  assign rsp.rem  = rem_r;
endmodule

// ===== design/pwa_store.sv =====
// Waveform bin memory with one write port and one registered read port.
module pwa_store #(
  parameter int DEPTH = 8192,
  parameter int AW    = 13
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [pwa_pkg::VAL_W-1:0]  wdata,
  input  logic                       re,
  input  logic [AW-1:0]              raddr,
  output logic [pwa_pkg::VAL_W-1:0]  rdata
);
  import pwa_pkg::*;

  logic [VAL_W-1:0] mem [DEPTH];
  logic [VAL_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

// ===== design/pulse_waveform_accumulator.sv =====
// Top level: request sequencer of the pulse waveform accumulator.
//
// Channel  Dir  Signals                        Contents
// in_      in   in_tvalid/in_tready/in_tdata   operation, channel, time, amp, length, bin
// out_     out  out_tvalid/out_tready/out_tdata  bin_value of a read
// cfg_     in   cfg_valid/cfg_ready/cfg_index/cfg_data  shape_mode, bin_width_ns
//
// A deposit runs up to three divisions on the shared divider, then one
// read-modify-write of the store per touched bin. A clear zeroes the NUM_BINS
// words of one channel. After reset a clearing pass writes all
// NUM_CHANNELS*NUM_BINS words, one per cycle, with in_tready low.
// A pending result does not block the next request; a read waits for out_tready.
module pulse_waveform_accumulator #(
  parameter int NUM_BINS     = 2048,
  parameter int NUM_CHANNELS = 4
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // operation[1:0], channel[3:2], start_time_ns[23:4], amplitude[39:24],
  // length_ns[55:40], bin_index[66:56], zeros above
  input  logic [pwa_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // bin_value[31:0]
  output logic [pwa_pkg::VAL_W-1:0]       out_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pwa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pwa_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import pwa_pkg::*;
  `include "assert_macros.svh"

  localparam int STORE_WORDS = NUM_CHANNELS * NUM_BINS;
  localparam int ADDR_W      = $clog2(STORE_WORDS);
  localparam int BIN_W       = $clog2(NUM_BINS);
  localparam int B_W         = T_W + 1;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_CLR, S_FIRST, S_N, S_MUL, S_STEP,
    S_BIN_RD, S_BIN_WR, S_RD_ISSUE, S_RD_DATA
  } state_t;

  state_t            state_r;
  logic              shape_r;
  logic [BW_W-1:0]   width_r;
  logic [ADDR_W-1:0] base_r;
  logic [ADDR_W-1:0] cnt_r;
  logic [T_W-1:0]    t_r;
  logic [AMP_W-1:0]  amp_r;
  logic [LEN_W-1:0]  len_r;
  logic [IDX_W-1:0]  idx_r;
  logic              rd_zero_r;
  logic [T_W-1:0]    first_r;
  logic [LEN_W-1:0]  n_r;
  logic [DEN_W-1:0]  nn_r;
  logic [B_W-1:0]    last_r;
  logic [B_W-1:0]    b_r;
  logic [NUM_W-1:0]  kdiv_r;
  logic [DEN_W-1:0]  kmod_r;
  logic [NUM_W-1:0]  q_r;
  logic [DEN_W-1:0]  r_r;
  logic [LEN_W-1:0]  d_r;
  logic              div_start_r;
  logic              out_valid_r;
  logic [VAL_W-1:0]  out_data_r;

  logic [OP_W-1:0]   in_op;
  logic [CH_W-1:0]   in_ch;
  logic [T_W-1:0]    in_t;
  logic [AMP_W-1:0]  in_amp;
  logic [LEN_W-1:0]  in_len;
  logic [IDX_W-1:0]  in_idx;
  logic              in_ch_ok;

  div_req_t          div_req;
  div_rsp_t          div_rsp;
  logic [BW_W-1:0]   w_eff;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [VAL_W-1:0]  mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic [VAL_W-1:0]  mem_rdata;
  logic [ADDR_W-1:0] bin_addr;

  logic [NUM_W-1:0]  addend;
  logic [VAL_W:0]    sum;
  logic [VAL_W-1:0]  sat_val;
  logic [LEN_W:0]    d1;
  logic [LEN_W+1:0]  two_d1;
  logic [LEN_W+1:0]  two_d;
  logic              step_up;
  logic              step_hold;
  logic [DEN_W:0]    r_up;
  logic [DEN_W:0]    r_dn;
  logic [NUM_W-1:0]  q_nxt;
  logic [DEN_W-1:0]  r_nxt;
  logic [B_W-1:0]    b1;
  logic [B_W-1:0]    first_end;

  assign in_op    = in_tdata[1:0];
  assign in_ch    = in_tdata[3:2];
  assign in_t     = in_tdata[23:4];
  assign in_amp   = in_tdata[39:24];
  assign in_len   = in_tdata[55:40];
  assign in_idx   = in_tdata[66:56];
  assign in_ch_ok = int'(in_ch) < NUM_CHANNELS;

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign w_eff = (width_r == '0) ? BW_W'(1) : width_r;

  always_comb begin
    div_req.start = div_start_r;
    div_req.num   = '0;
    div_req.den   = '0;
    unique case (state_r)
      S_FIRST: begin
        div_req.num = NUM_W'(t_r);
        div_req.den = DEN_W'(w_eff);
      end
      S_N: begin
        div_req.num = NUM_W'({1'b0, len_r} + (LEN_W+1)'(w_eff) - (LEN_W+1)'(1));
        div_req.den = DEN_W'(w_eff);
      end
      S_STEP: begin
        if (shape_r) begin
          div_req.num = {amp_r, 10'b0};
          div_req.den = nn_r;
        end else begin
          div_req.num = NUM_W'({amp_r, 8'b0});
          div_req.den = DEN_W'(n_r);
        end
      end
      default: begin
      end
    endcase
  end

  pwa_div u_div (
    .clk (clk),
    .rst_n (rst_n),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign bin_addr = base_r + ADDR_W'(b_r[BIN_W-1:0]);

  assign addend  = shape_r ? q_r : kdiv_r;
  assign sum     = {1'b0, mem_rdata} + (VAL_W+1)'(addend);
  assign sat_val = sum[VAL_W] ? '1 : sum[VAL_W-1:0];

  assign d1        = {1'b0, d_r} + (LEN_W+1)'(1);
  assign two_d1    = {d1, 1'b0};
  assign two_d     = {1'b0, d_r, 1'b0};
  assign step_up   = two_d1 <= (LEN_W+2)'(n_r);
  assign step_hold = !step_up && (two_d <= (LEN_W+2)'(n_r)) && n_r[0];
  assign r_up      = {1'b0, r_r} + {1'b0, kmod_r};
  assign r_dn      = {1'b0, r_r} - {1'b0, kmod_r};
  assign b1        = b_r + B_W'(1);
  assign first_end = B_W'(first_r) + B_W'(n_r);

  always_comb begin
    q_nxt = q_r;
    r_nxt = r_r;
    if (step_up) begin
      if (r_up >= {1'b0, nn_r}) begin
        r_nxt = DEN_W'(r_up - {1'b0, nn_r});
        q_nxt = q_r + kdiv_r + NUM_W'(1);
      end else begin
        r_nxt = r_up[DEN_W-1:0];
        q_nxt = q_r + kdiv_r;
      end
    end else if (!step_hold) begin
      if (r_dn[DEN_W]) begin
        r_nxt = r_dn[DEN_W-1:0] + nn_r;
        q_nxt = q_r - kdiv_r - NUM_W'(1);
      end else begin
        r_nxt = r_dn[DEN_W-1:0];
        q_nxt = q_r - kdiv_r;
      end
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;
    unique case (state_r)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_r;
      end
      S_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = base_r + cnt_r;
      end
      S_BIN_RD: begin
        mem_re    = 1'b1;
        mem_raddr = bin_addr;
      end
      S_BIN_WR: begin
        mem_we    = 1'b1;
        mem_waddr = bin_addr;
        mem_wdata = sat_val;
      end
      S_RD_ISSUE: begin
        mem_re    = 1'b1;
        mem_raddr = base_r + ADDR_W'(idx_r);
      end
      default: begin
      end
    endcase
  end

  pwa_store #(
    .DEPTH (STORE_WORDS),
    .AW    (ADDR_W)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      cnt_r       <= '0;
      shape_r     <= 1'b1;
      width_r     <= BW_W'(2);
      div_start_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      div_start_r <= 1'b0;
      if (out_tready && (state_r != S_RD_DATA)) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_SHAPE:     shape_r <= cfg_data[0];
          REG_BIN_WIDTH: width_r <= cfg_data;
          default: begin
          end
        endcase
      end
      unique case (state_r)
        S_INIT: begin
          cnt_r <= cnt_r + ADDR_W'(1);
          if (cnt_r == ADDR_W'(STORE_WORDS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_tvalid) begin
            base_r    <= ADDR_W'(int'(in_ch) * NUM_BINS);
            t_r       <= in_t;
            amp_r     <= in_amp;
            len_r     <= in_len;
            idx_r     <= in_idx;
            cnt_r     <= '0;
            rd_zero_r <= !(in_ch_ok && (int'(in_idx) < NUM_BINS));
            unique case (in_op)
              OP_DEPOSIT: begin
                if (in_ch_ok && (in_len != '0)) begin
                  state_r     <= S_FIRST;
                  div_start_r <= 1'b1;
                end
              end
              OP_READ: begin
                if (in_ch_ok && (int'(in_idx) < NUM_BINS)) begin
                  state_r <= S_RD_ISSUE;
                end else begin
                  state_r <= S_RD_DATA;
                end
              end
              OP_CLEAR: begin
                if (in_ch_ok) begin
                  state_r <= S_CLR;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_CLR: begin
          cnt_r <= cnt_r + ADDR_W'(1);
          if (cnt_r == ADDR_W'(NUM_BINS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_FIRST: begin
          if (div_rsp.done) begin
            first_r     <= div_rsp.quot[T_W-1:0];
            div_start_r <= 1'b1;
            state_r     <= S_N;
          end
        end
        S_N: begin
          if (div_rsp.done) begin
            n_r     <= div_rsp.quot[LEN_W-1:0];
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          nn_r   <= DEN_W'(n_r) * DEN_W'(n_r);
          b_r    <= B_W'(first_r);
          last_r <= (first_end > B_W'(NUM_BINS)) ? B_W'(NUM_BINS) : first_end;
          if (B_W'(first_r) >= B_W'(NUM_BINS)) begin
            state_r <= S_IDLE;
          end else begin
            div_start_r <= 1'b1;
            state_r     <= S_STEP;
          end
        end
        S_STEP: begin
          if (div_rsp.done) begin
            kdiv_r  <= div_rsp.quot;
            kmod_r  <= div_rsp.rem;
            q_r     <= '0;
            r_r     <= '0;
            d_r     <= '0;
            state_r <= S_BIN_RD;
          end
        end
        S_BIN_RD: begin
          state_r <= S_BIN_WR;
        end
        S_BIN_WR: begin
          q_r <= q_nxt;
          r_r <= r_nxt;
          d_r <= d1[LEN_W-1:0];
          b_r <= b1;
          if (b1 >= last_r) begin
            state_r <= S_IDLE;
          end else begin
            state_r <= S_BIN_RD;
          end
        end
        S_RD_ISSUE: begin
          state_r <= S_RD_DATA;
        end
        S_RD_DATA: begin
          if (!out_valid_r || out_tready) begin
            out_data_r  <= rd_zero_r ? '0 : mem_rdata;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  `ASSERT_NEVER(a_no_write_idle, clk, rst_n, (state_r == S_IDLE) && mem_we)
  `ASSERT_NEVER(a_div_start_busy, clk, rst_n, div_req.start && div_rsp.busy)
  `ASSERT_CLK(a_bin_in_range, clk, rst_n, (state_r == S_BIN_WR) |-> (b_r < B_W'(NUM_BINS)))
  `ASSERT_CLK(a_out_from_read, clk, rst_n, $rose(out_valid_r) |-> $past(state_r == S_RD_DATA))
endmodule
